// ===== hw/rtl/rpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Response pattern matcher package
// Shared constants, codes and the match state record of the matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpm_pkg;

  // pattern capacity and field widths
  localparam int MaxPatternDefault = 32;
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 6;
  localparam int IDLE_W    = 17;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PAT_W     = 4 * CFG_W;
  localparam int PAT_IDX_W = 5;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);

  // input transaction kinds
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // search status reported with every result
  typedef enum logic [STATUS_W-1:0] {
    ST_SEARCHING = 2'd0,
    ST_FOUND     = 2'd1,
    ST_TIMEOUT   = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_LENGTH    = 3'd4,
    CFG_TIMEOUT   = 3'd5
  } cfg_idx_e;

  // search state carried from one transaction to the next
  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   pos;
    logic [IDLE_W-1:0]  idle;
  } match_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpm_step.sv =====
// ----------------------------------------------------------------------------
// Response pattern matcher step
// Next search state for one transaction: start, received byte or tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpm_step #(
  parameter int MAX_PATTERN = rpm_pkg::MaxPatternDefault
) (
  input  wire rpm_pkg::match_state_t                state_i,
  input  wire logic [rpm_pkg::OP_W-1:0]             op_i,
  input  wire logic [rpm_pkg::BYTE_W-1:0]           byte_i,
  input  wire logic [rpm_pkg::PAT_W-1:0]            pattern_i,
  input  wire logic [rpm_pkg::POS_W-1:0]            length_i,
  input  wire logic [rpm_pkg::TIMEOUT_W-1:0]        timeout_i,
  output rpm_pkg::match_state_t                     state_o
);

  localparam logic [rpm_pkg::POS_W-1:0] MaxLen = rpm_pkg::POS_W'(MAX_PATTERN);

  logic [rpm_pkg::POS_W-1:0]  len;
  logic [rpm_pkg::BYTE_W-1:0] pat_cur;
  logic [rpm_pkg::BYTE_W-1:0] pat_first;
  logic [rpm_pkg::POS_W-1:0]  pos_n;
  logic [rpm_pkg::IDLE_W-1:0] idle_n;
  logic [rpm_pkg::IDLE_W-1:0] timeout_ext;

  // effective length saturates at the pattern capacity
  assign len = (length_i > MaxLen) ? MaxLen : length_i;

  // pattern byte at the current position and the first pattern byte
  assign pat_cur   = pattern_i[{state_i.pos[rpm_pkg::PAT_IDX_W-1:0], 3'b000} +: rpm_pkg::BYTE_W];
  assign pat_first = pattern_i[rpm_pkg::BYTE_W-1:0];

  assign timeout_ext = {{(rpm_pkg::IDLE_W - rpm_pkg::TIMEOUT_W){1'b0}}, timeout_i};

  // byte compare with naive restart
  always_comb begin
    pos_n = state_i.pos;
    if (state_i.pos < len) begin
      if (byte_i == pat_cur) begin
        pos_n = state_i.pos + rpm_pkg::POS_W'(1);
      end else if (byte_i == pat_first) begin
        pos_n = rpm_pkg::POS_W'(1);
      end else begin
        pos_n = '0;
      end
    end
  end

  // saturating idle tick count
  assign idle_n = (state_i.idle != '1) ? state_i.idle + rpm_pkg::IDLE_W'(1) : state_i.idle;

  // state update per transaction kind
  always_comb begin
    state_o = state_i;
    case (op_i)
      rpm_pkg::OP_START: begin
        state_o.pos    = '0;
        state_o.idle   = '0;
        state_o.status = (len == '0) ? rpm_pkg::ST_FOUND : rpm_pkg::ST_SEARCHING;
      end
      rpm_pkg::OP_BYTE: begin
        if (state_i.status == rpm_pkg::ST_SEARCHING) begin
          state_o.idle = '0;
          state_o.pos  = pos_n;
          if (pos_n >= len) begin
            state_o.status = rpm_pkg::ST_FOUND;
          end
        end
      end
      rpm_pkg::OP_TICK: begin
        if (state_i.status == rpm_pkg::ST_SEARCHING) begin
          state_o.idle = idle_n;
          if ((timeout_i != '0) && (idle_n > timeout_ext)) begin
            state_o.status = rpm_pkg::ST_TIMEOUT;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/response_pattern_matcher.sv =====
// An accepted input transaction passes the input register, then the result register,
// which presents its result.
// Throughput: one transaction per cycle unless the result stalls; the state register
// feeds the combinational step unit, so each transaction sees the state left by the one before.
// Reset: asynchronous, active low; search state cleared to searching at position 0,
// pattern and length cleared, timeout set to 1000 ticks; pipeline emptied.
// ----------------------------------------------------------------------------
// Response pattern matcher
// Streams bytes against a configured pattern with an idle tick timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module response_pattern_matcher #(
  parameter int MAX_PATTERN = rpm_pkg::MaxPatternDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [rpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rpm_pkg::CFG_W-1:0]       cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  wire logic [1:0]                      s_axis_tuser,  // [1:0] op
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata   // [1:0] status, [7:2] matched_count
);

  logic [rpm_pkg::PAT_W-1:0]     pattern_q;
  logic [rpm_pkg::POS_W-1:0]     length_q;
  logic [rpm_pkg::TIMEOUT_W-1:0] timeout_q;

  logic                          in_valid_q;
  logic [rpm_pkg::OP_W-1:0]      in_op_q;
  logic [rpm_pkg::BYTE_W-1:0]    in_byte_q;

  logic                          out_valid_q;
  rpm_pkg::status_e              out_status_q;
  logic [rpm_pkg::POS_W-1:0]     out_pos_q;

  rpm_pkg::match_state_t         state_q;
  rpm_pkg::match_state_t         state_d;

  logic                          adv;
  logic                          in_accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= '0;
      timeout_q <= rpm_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpm_pkg::CFG_PAT_0_7:   pattern_q[0*rpm_pkg::CFG_W +: rpm_pkg::CFG_W] <= cfg_data_i;
        rpm_pkg::CFG_PAT_8_15:  pattern_q[1*rpm_pkg::CFG_W +: rpm_pkg::CFG_W] <= cfg_data_i;
        rpm_pkg::CFG_PAT_16_23: pattern_q[2*rpm_pkg::CFG_W +: rpm_pkg::CFG_W] <= cfg_data_i;
        rpm_pkg::CFG_PAT_24_31: pattern_q[3*rpm_pkg::CFG_W +: rpm_pkg::CFG_W] <= cfg_data_i;
        rpm_pkg::CFG_LENGTH:    length_q  <= cfg_data_i[rpm_pkg::POS_W-1:0];
        rpm_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data_i[rpm_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the step stage advances when the result register is free or drains
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= s_axis_tuser[rpm_pkg::OP_W-1:0];
      in_byte_q <= s_axis_tdata[rpm_pkg::BYTE_W-1:0];
    end
  end

  // next search state
  rpm_step #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_step (
    .state_i   (state_q),
    .op_i      (in_op_q),
    .byte_i    (in_byte_q),
    .pattern_i (pattern_q),
    .length_i  (length_q),
    .timeout_i (timeout_q),
    .state_o   (state_d)
  );

  // search state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.status <= rpm_pkg::ST_SEARCHING;
      state_q.pos    <= '0;
      state_q.idle   <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= state_d.status;
      out_pos_q    <= state_d.pos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pos_q, out_status_q};

  // match position never passes the pattern capacity
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= rpm_pkg::POS_W'(MAX_PATTERN))
    else $error("match position beyond pattern capacity");

  // a byte while searching clears the idle count
  a_byte_clears_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_op_q == rpm_pkg::OP_BYTE) && (state_q.status == rpm_pkg::ST_SEARCHING))
    |=> (state_q.idle == '0))
    else $error("idle count not cleared by received byte");

  // state moves only when a transaction passes the step stage
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("search state changed without a transaction");

  // the result reports the state left by its transaction
  a_result_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_valid_q && (out_pos_q == state_q.pos) && (out_status_q == state_q.status)))
    else $error("result does not match search state");

endmodule

`default_nettype wire
